// ----- rtl/mcm_pkg.sv -----
// Package for the Montgomery cube block: function codes, controller states,
// datapath micro-ops and the command struct. No dependencies.
package mcm_pkg;

    typedef enum logic [1:0] {
        F_LOAD_KEY = 2'd0,
        F_LOAD_SIG = 2'd1,
        F_COMPUTE  = 2'd2,
        F_READ     = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7,
        S_J0, S_J1, S_J2, S_J3,
        S_FIN
    } t_state;

    typedef enum logic [4:0] {
        U_NOP, U_LDK, U_LDS, U_RD, U_CLR,
        U_R0, U_R1, U_R2, U_R3, U_R4, U_R5, U_R6, U_R7,
        U_J0, U_J1, U_J2, U_J3,
        U_FIN
    } t_uop;

    // Pass 0: sq = s*s, pass 1: cube = sq*s, pass 2: res = cube*1
    localparam logic [1:0] PASS_SQ   = 2'd0;
    localparam logic [1:0] PASS_CUBE = 2'd1;
    localparam logic [1:0] PASS_RES  = 2'd2;

    typedef struct packed {
        t_uop       uop;
        logic [1:0] pass;
    } t_dp_cmd;

endpackage

// ----- rtl/montgomery_cube_modexp.sv -----
// Top level of the Montgomery cube block: controller plus datapath.
// Depends on mcm_pkg, mcm_ctrl and mcm_dp.
//
//  channel  handshake              fields
//  input    start & !busy          i_func, i_word_index, i_word_value
//  result   o_strobe (one cycle)   o_result_word, o_done_flag
//
// Loads leave busy low; a read gives its word the cycle after acceptance.
// A compute holds busy through three passes on one shared 32x32 multiplier,
// with word steps in states S_J0 to S_J3, and then strobes done.
// Reset is synchronous, active low. Results cannot be stalled.
module montgomery_cube_modexp #(
    parameter int NUM_WORDS = 96
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [6:0]  i_word_index,
    input  logic [31:0] i_word_value,
    output logic        o_strobe,
    output logic [31:0] o_result_word,
    output logic        o_done_flag
);
    import mcm_pkg::*;

    localparam int AW = $clog2(NUM_WORDS);

    t_dp_cmd       cmd;
    logic [AW-1:0] k, j;

    mcm_ctrl #(.NUM_WORDS(NUM_WORDS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .o_cmd       (cmd),
        .o_k         (k),
        .o_j         (j),
        .o_strobe    (o_strobe),
        .o_done_flag (o_done_flag)
    );

    mcm_dp #(.NUM_WORDS(NUM_WORDS)) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_k           (k),
        .i_j           (j),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .o_result_word (o_result_word)
    );

endmodule

// ----- rtl/mcm_ctrl.sv -----
// Controller of the Montgomery cube block: sequences clear sweeps, round
// setup and word steps of the three passes. Depends on mcm_pkg.
module mcm_ctrl #(
    parameter int NUM_WORDS = 96
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    output mcm_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(NUM_WORDS)-1:0] o_k,
    output logic [$clog2(NUM_WORDS)-1:0] o_j,
    output logic                         o_strobe,
    output logic                         o_done_flag
);
    import mcm_pkg::*;

    localparam int AW = $clog2(NUM_WORDS);

    t_state        r_state, n_state;
    logic [1:0]    r_pass, n_pass;
    logic [AW-1:0] r_k, n_k, r_j, n_j;
    logic          r_strobe, n_strobe, r_done, n_done;
    logic          last_round;

    assign last_round = (r_k == AW'(NUM_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= PASS_SQ;
            r_k      <= '0;
            r_j      <= '0;
            r_strobe <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pass   <= n_pass;
            r_k      <= n_k;
            r_j      <= n_j;
            r_strobe <= n_strobe;
            r_done   <= n_done;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_pass   = r_pass;
        n_k      = r_k;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == F_COMPUTE) begin
                        n_state = S_CLR;
                        n_pass  = PASS_SQ;
                        n_j     = '0;
                    end else if (i_func == F_READ) begin
                        n_strobe = 1'b1;
                    end
                end
            end
            S_CLR: begin
                if (r_j == AW'(NUM_WORDS - 1)) begin
                    n_state = S_R0;
                    n_k     = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_R0: n_state = S_R1;
            S_R1: n_state = S_R2;
            S_R2: n_state = S_R3;
            S_R3: n_state = S_R4;
            S_R4: n_state = S_R5;
            S_R5: n_state = S_R6;
            S_R6: n_state = S_R7;
            S_R7: begin
                n_state = S_J0;
                n_j     = '0;
            end
            S_J0: n_state = S_J1;
            S_J1: n_state = S_J2;
            S_J2: n_state = S_J3;
            S_J3: begin
                if (r_j == AW'(NUM_WORDS - 2)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_J0;
                    n_j     = r_j + 1'b1;
                end
            end
            S_FIN: begin
                if (!last_round) begin
                    n_state = S_R0;
                    n_k     = r_k + 1'b1;
                end else if (r_pass == PASS_RES) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_done   = 1'b1;
                end else begin
                    n_state = S_CLR;
                    n_pass  = r_pass + 1'b1;
                    n_j     = '0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.pass = r_pass;
        o_cmd.uop  = U_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        F_LOAD_KEY: o_cmd.uop = U_LDK;
                        F_LOAD_SIG: o_cmd.uop = U_LDS;
                        F_READ:     o_cmd.uop = U_RD;
                        default:    o_cmd.uop = U_NOP;
                    endcase
                end
            end
            S_CLR:   o_cmd.uop = U_CLR;
            S_R0:    o_cmd.uop = U_R0;
            S_R1:    o_cmd.uop = U_R1;
            S_R2:    o_cmd.uop = U_R2;
            S_R3:    o_cmd.uop = U_R3;
            S_R4:    o_cmd.uop = U_R4;
            S_R5:    o_cmd.uop = U_R5;
            S_R6:    o_cmd.uop = U_R6;
            S_R7:    o_cmd.uop = U_R7;
            S_J0:    o_cmd.uop = U_J0;
            S_J1:    o_cmd.uop = U_J1;
            S_J2:    o_cmd.uop = U_J2;
            S_J3:    o_cmd.uop = U_J3;
            S_FIN:   o_cmd.uop = U_FIN;
            default: o_cmd.uop = U_NOP;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_k         = r_k;
    assign o_j         = r_j;
    assign o_strobe    = r_strobe;
    assign o_done_flag = r_done;

endmodule

// ----- rtl/mcm_dp.sv -----
// Datapath of the Montgomery cube block: word stores, one shared 32x32
// multiplier and the round registers. Depends on mcm_pkg.
module mcm_dp #(
    parameter int NUM_WORDS = 96
) (
    input  logic                         i_clk,
    input  mcm_pkg::t_dp_cmd             i_cmd,
    input  logic [$clog2(NUM_WORDS)-1:0] i_k,
    input  logic [$clog2(NUM_WORDS)-1:0] i_j,
    input  logic [6:0]                   i_word_index,
    input  logic [31:0]                  i_word_value,
    output logic [31:0]                  o_result_word
);
    import mcm_pkg::*;

    localparam int AW = $clog2(NUM_WORDS);
    localparam int KW = $clog2(NUM_WORDS + 1);

    logic [31:0] key_mem  [NUM_WORDS+1];
    logic [31:0] sig_mem  [NUM_WORDS];
    logic [31:0] sq_mem   [NUM_WORDS];
    logic [31:0] cube_mem [NUM_WORDS];
    logic [31:0] res_mem  [NUM_WORDS];

    logic [31:0] r_key_q, r_sig_q, r_sq_q, r_cube_q, r_res_q;
    logic [31:0] r_m, r_kf, r_q, r_accv, r_keyv, r_lo, r_hi_a, r_hi_b;
    logic [63:0] r_prod;
    logic        r_rd_ok;

    logic [KW-1:0] key_ra;
    logic [AW-1:0] y_addr, sig_ra, sq_ra, res_ra, acc_wa, idx_a;
    logic [31:0]   x_data, y_data, acc_data, acc_wd, mul_a, mul_b;
    logic [63:0]   sum_u, sum_t0, sum_t, sum_r3;
    logic          acc_we, idx_in_key, idx_in_num;

    assign idx_a      = AW'(i_word_index);
    assign idx_in_key = (32'(i_word_index) <= NUM_WORDS);
    assign idx_in_num = (32'(i_word_index) < NUM_WORDS);

    assign y_addr = (i_cmd.uop == U_R1) ? '0 : i_j + 1'b1;
    assign sig_ra = (i_cmd.uop == U_R0) ? i_k : y_addr;
    assign sq_ra  = (i_cmd.uop == U_R0) ? i_k : y_addr;
    assign res_ra = (i_cmd.uop == U_RD) ? idx_a : y_addr;

    always_comb begin
        case (i_cmd.uop)
            U_R1:    key_ra = '0;
            U_R2:    key_ra = KW'(1);
            default: key_ra = KW'(i_j) + KW'(2);
        endcase
    end

    assign x_data   = (i_cmd.pass == PASS_SQ) ? r_sig_q : r_sq_q;
    assign y_data   = (i_cmd.pass == PASS_RES) ? r_cube_q : r_sig_q;
    assign acc_data = (i_cmd.pass == PASS_SQ)   ? r_sq_q :
                      (i_cmd.pass == PASS_CUBE) ? r_cube_q : r_res_q;

    always_comb begin
        case (i_cmd.uop)
            U_R4: begin
                mul_a = r_lo;
                mul_b = r_kf;
            end
            U_R6, U_J2: begin
                mul_a = r_q;
                mul_b = r_keyv;
            end
            default: begin
                mul_a = r_m;
                mul_b = y_data;
            end
        endcase
    end

    assign sum_r3 = {32'b0, r_accv} + r_prod;
    assign sum_t0 = {32'b0, r_lo} + r_prod;
    assign sum_u  = {32'b0, r_hi_a} + r_prod + {32'b0, r_accv};
    assign sum_t  = {32'b0, r_hi_b} + r_prod + {32'b0, r_lo};

    always_comb begin
        acc_we = 1'b0;
        acc_wa = i_j;
        acc_wd = '0;
        case (i_cmd.uop)
            U_CLR: acc_we = 1'b1;
            U_J3: begin
                acc_we = 1'b1;
                acc_wd = sum_t[31:0];
            end
            U_FIN: begin
                acc_we = 1'b1;
                acc_wa = AW'(NUM_WORDS - 1);
                acc_wd = r_hi_a + r_hi_b;
            end
            default: acc_we = 1'b0;
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == U_LDK && idx_in_key) key_mem[KW'(i_word_index)] <= i_word_value;
        if (i_cmd.uop == U_LDS && idx_in_num) sig_mem[idx_a] <= i_word_value;
        if (acc_we && i_cmd.pass == PASS_SQ)   sq_mem[acc_wa]   <= acc_wd;
        if (acc_we && i_cmd.pass == PASS_CUBE) cube_mem[acc_wa] <= acc_wd;
        if (acc_we && i_cmd.pass == PASS_RES)  res_mem[acc_wa]  <= acc_wd;
        r_key_q  <= key_mem[key_ra];
        r_sig_q  <= sig_mem[sig_ra];
        r_sq_q   <= sq_mem[sq_ra];
        r_cube_q <= cube_mem[y_addr];
        r_res_q  <= res_mem[res_ra];
    end

    // round registers
    always_ff @(posedge i_clk) begin
        r_rd_ok <= (i_cmd.uop == U_RD) && idx_in_num;
        case (i_cmd.uop)
            U_R1: begin
                if (i_cmd.pass == PASS_RES) r_m <= (i_k == '0) ? 32'd1 : 32'd0;
                else                        r_m <= x_data;
            end
            U_R2: begin
                r_prod <= mul_a * mul_b;
                r_kf   <= r_key_q;
                r_accv <= acc_data;
            end
            U_R3: begin
                r_hi_a <= sum_r3[63:32];
                r_lo   <= sum_r3[31:0];
                r_keyv <= r_key_q;
            end
            U_R4: r_prod <= mul_a * mul_b;
            U_R5: r_q    <= r_prod[31:0];
            U_R6: r_prod <= mul_a * mul_b;
            U_R7: r_hi_b <= sum_t0[63:32];
            U_J1: begin
                r_prod <= mul_a * mul_b;
                r_accv <= acc_data;
                r_keyv <= r_key_q;
            end
            U_J2: begin
                r_hi_a <= sum_u[63:32];
                r_lo   <= sum_u[31:0];
                r_prod <= mul_a * mul_b;
            end
            U_J3: r_hi_b <= sum_t[63:32];
            default: r_m <= r_m;
        endcase
    end

    assign o_result_word = r_rd_ok ? r_res_q : '0;

endmodule

// ----- rtl/mcm_checker.sv -----
// Port-level checks for the Montgomery cube block, bound to the top level.
// Depends on mcm_pkg and montgomery_cube_modexp.
module mcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_func,
    input logic        o_strobe,
    input logic [31:0] o_result_word,
    input logic        o_done_flag
);
    import mcm_pkg::*;

    a_done_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_strobe |-> !o_done_flag) else $error("done without strobe");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_done_flag |-> o_result_word == 32'd0)
        else $error("done word not zero");

    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == F_READ |=> o_strobe && !o_done_flag)
        else $error("read word missing");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_func == F_LOAD_KEY || i_func == F_LOAD_SIG) |=> !o_strobe)
        else $error("load gave a word");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == F_COMPUTE |=> busy && !o_strobe)
        else $error("compute not busy");

endmodule

bind montgomery_cube_modexp mcm_checker u_mcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .o_strobe      (o_strobe),
    .o_result_word (o_result_word),
    .o_done_flag   (o_done_flag)
);
